// ===== hw/rtl/enpp_pkg.sv =====
// Shared widths, codes and types for the elastic-net pointwise penalty block.
`default_nettype none
package enpp_pkg;
	localparam int X_W        = 32;
	localparam int EPS_W      = 31;
	localparam int WGT_W      = 17;
	localparam int PEN_W      = 47;
	localparam int SLP_W      = 40;
	localparam int CRV_W      = 47;
	localparam int REGION_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int DIV_DW     = 32;
	localparam int DIV_QW     = 48;
	localparam int PBASE_W    = 39;
	localparam int SBASE_W    = 34;

	localparam logic [CFG_IDX_W-1:0] CFG_EPSILON  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_L1       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_L2       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

	localparam logic [EPS_W-1:0] EPS_RESET = 31'd16777216;
	localparam logic [WGT_W-1:0] L1_RESET  = 17'd65536;
	localparam logic [WGT_W-1:0] L2_RESET  = 17'd0;

	localparam logic [REGION_W-1:0] REGION_IN    = 2'd0;
	localparam logic [REGION_W-1:0] REGION_ABOVE = 2'd1;
	localparam logic [REGION_W-1:0] REGION_BELOW = 2'd2;

	typedef struct packed {
		logic                    neg;
		logic                    in_band;
		logic [REGION_W-1:0]     region;
		logic [PBASE_W-1:0]      pen_base;
		logic [SBASE_W-1:0]      slope_base;
	} side_t;
endpackage
`default_nettype wire

// ===== hw/rtl/enpp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module enpp_div #(
	parameter int NW = 49,
	parameter int DW = enpp_pkg::DIV_DW,
	parameter int QW = enpp_pkg::DIV_QW
) (
	input  wire logic          clk,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic      [QW-1:0] quo
);
	logic [DW-1:0] rem_s [0:QW];
	logic [QW-1:0] low_s [0:QW-1];
	logic [DW-1:0] den_s [0:QW-1];
	logic [QW-1:0] quo_s [0:QW];

	always_ff @(posedge clk) begin
		rem_s[0] <= DW'(num[NW-1:QW]);
		low_s[0] <= num[QW-1:0];
		den_s[0] <= den;
		quo_s[0] <= '0;
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DW:0] trial;
		logic        take;
		always_comb begin
			trial = {rem_s[k], low_s[k][QW-1]};
			take  = trial >= {1'b0, den_s[k]};
		end
		always_ff @(posedge clk) begin
			rem_s[k+1] <= take ? DW'(trial - {1'b0, den_s[k]}) : trial[DW-1:0];
			quo_s[k+1] <= {quo_s[k][QW-2:0], take};
		end
		if (k < QW - 1) begin : g_pass
			always_ff @(posedge clk) begin
				low_s[k+1] <= low_s[k] << 1;
				den_s[k+1] <= den_s[k];
			end
		end
	end

	assign quo = quo_s[QW];
endmodule
`default_nettype wire

// ===== hw/rtl/elastic_net_pointwise_penalty.sv =====
// Top level of the elastic-net pointwise penalty pipeline.
//  channel  | handshake               | payload
//  input    | start / busy            | x
//  result   | done (strobe)           | penalty, slope, curvature, region
//  config   | cfg_valid / cfg_ready   | cfg_index, cfg_data
// One transaction enters per cycle; busy stays low.
// Four arithmetic stages, 49 divider stages and one output stage.
// The three dividers retire one quotient bit per stage and set the depth.
// Reset clears the valid chain and loads register defaults; no clearing pass.
// The result side has no back-pressure, so nothing stalls.
`default_nettype none
module elastic_net_pointwise_penalty (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic signed [enpp_pkg::X_W-1:0]      x,
	output logic                                      done,
	output logic        [enpp_pkg::PEN_W-1:0]         penalty,
	output logic signed [enpp_pkg::SLP_W-1:0]         slope,
	output logic        [enpp_pkg::CRV_W-1:0]         curvature,
	output logic        [enpp_pkg::REGION_W-1:0]      region,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic   [enpp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic   [enpp_pkg::CFG_DATA_W-1:0]    cfg_data
);
	localparam int QW  = enpp_pkg::DIV_QW;
	localparam int LAT = QW + 6;

	logic [enpp_pkg::EPS_W-1:0] eps_q;
	logic [enpp_pkg::WGT_W-1:0] l1_q;
	logic [enpp_pkg::WGT_W-1:0] l2_q;
	logic [enpp_pkg::EPS_W-1:0] e_eff;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= enpp_pkg::EPS_RESET;
			l1_q  <= enpp_pkg::L1_RESET;
			l2_q  <= enpp_pkg::L2_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				enpp_pkg::CFG_EPSILON: eps_q <= cfg_data[enpp_pkg::EPS_W-1:0];
				enpp_pkg::CFG_L1:      l1_q  <= cfg_data[enpp_pkg::WGT_W-1:0];
				enpp_pkg::CFG_L2:      l2_q  <= cfg_data[enpp_pkg::WGT_W-1:0];
				default: ;
			endcase
		end
	end

	assign e_eff = (eps_q == '0) ? 31'd1 : eps_q;

	// stage 1: magnitude and band test
	logic [31:0] x_mag;
	logic        vld_s1, neg_s1, out_s1;
	logic [31:0] mag_s1;

	assign x_mag = x[31] ? (~x + 32'd1) : x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1 <= x[31];
		mag_s1 <= x_mag;
		out_s1 <= x_mag > {1'b0, e_eff};
	end

	// stage 2: square and weight products
	logic        vld_s2, neg_s2, out_s2;
	logic [31:0] mag_s2;
	logic [63:0] sq_s2;
	logic [48:0] l1m_s2, l2m_s2;
	logic [49:0] l1d_s2;
	logic [32:0] dif_s1;

	assign dif_s1 = {mag_s1, 1'b0} - {2'b00, e_eff};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		neg_s2 <= neg_s1;
		out_s2 <= out_s1;
		mag_s2 <= mag_s1;
		sq_s2  <= mag_s1 * mag_s1;
		l1m_s2 <= l1_q * mag_s1;
		l2m_s2 <= l2_q * mag_s1;
		l1d_s2 <= l1_q * dif_s1;
	end

	// stage 3: split products of the square, linear penalty and slope base
	logic        vld_s3, neg_s3, out_s3;
	logic [31:0] mag_s3;
	logic [48:0] p1h_s3, p1l_s3, p2h_s3, p2l_s3, l1m_s3;
	logic [32:0] pen1_s3;
	logic [enpp_pkg::SBASE_W-1:0] sbase_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		neg_s3   <= neg_s2;
		out_s3   <= out_s2;
		mag_s3   <= mag_s2;
		l1m_s3   <= l1m_s2;
		p1h_s3   <= l1_q * sq_s2[63:32];
		p1l_s3   <= l1_q * sq_s2[31:0];
		p2h_s3   <= l2_q * sq_s2[63:32];
		p2l_s3   <= l2_q * sq_s2[31:0];
		pen1_s3  <= out_s2 ? l1d_s2[49:17] : 33'd0;
		sbase_s3 <= (out_s2 ? 34'({l1_q, 8'd0}) : 34'd0) + 34'(l2m_s2[48:16]);
	end

	// stage 4: full products, penalty base
	logic        vld_s4, neg_s4, out_s4;
	logic [31:0] mag_s4;
	logic [78:0] l1sq_s4;
	logic [48:0] l1m_s4;
	logic [78:0] l2sq;
	logic [enpp_pkg::PBASE_W-1:0] pbase_s4;
	logic [enpp_pkg::SBASE_W-1:0] sbase_s4;

	assign l2sq = 79'({p2h_s3, 32'd0}) + 79'(p2l_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		neg_s4   <= neg_s3;
		out_s4   <= out_s3;
		mag_s4   <= mag_s3;
		l1m_s4   <= l1m_s3;
		sbase_s4 <= sbase_s3;
		l1sq_s4  <= 79'({p1h_s3, 32'd0}) + 79'(p1l_s3);
		pbase_s4 <= 39'(pen1_s3) + 39'(l2sq[78:41]);
	end

	// dividers
	logic [48:0] num_c;
	logic [31:0] den_c, den_e;
	logic [78:0] num_p;
	logic [56:0] num_s;
	logic [QW-1:0] quo_c, quo_p, quo_s;

	assign num_c = out_s4 ? 49'({l1_q, 32'd0}) : 49'({l1_q, 31'd0});
	assign den_c = out_s4 ? mag_s4 : {1'b0, e_eff};
	assign den_e = {1'b0, e_eff};
	assign num_p = out_s4 ? 79'd0 : l1sq_s4;
	assign num_s = out_s4 ? 57'd0 : {l1m_s4, 8'd0};

	enpp_div #(.NW(49), .DW(enpp_pkg::DIV_DW), .QW(QW)) u_div_crv (
		.clk(clk), .num(num_c), .den(den_c), .quo(quo_c)
	);
	enpp_div #(.NW(79), .DW(enpp_pkg::DIV_DW), .QW(QW)) u_div_pen (
		.clk(clk), .num(num_p), .den(den_e), .quo(quo_p)
	);
	enpp_div #(.NW(57), .DW(enpp_pkg::DIV_DW), .QW(QW)) u_div_slp (
		.clk(clk), .num(num_s), .den(den_e), .quo(quo_s)
	);

	// side band alongside the dividers
	enpp_pkg::side_t side_d [0:QW];
	logic            vld_d  [0:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_d[0] <= 1'b0;
		end else begin
			vld_d[0] <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		side_d[0].neg        <= neg_s4;
		side_d[0].in_band    <= !out_s4;
		side_d[0].region     <= !out_s4 ? enpp_pkg::REGION_IN :
			(neg_s4 ? enpp_pkg::REGION_BELOW : enpp_pkg::REGION_ABOVE);
		side_d[0].pen_base   <= pbase_s4;
		side_d[0].slope_base <= sbase_s4;
	end

	for (genvar k = 0; k < QW; k++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_d[k+1] <= 1'b0;
			end else begin
				vld_d[k+1] <= vld_d[k];
			end
		end
		always_ff @(posedge clk) begin
			side_d[k+1] <= side_d[k];
		end
	end

	// output stage
	enpp_pkg::side_t fin;
	logic [39:0] pen_sum;
	logic [39:0] slp_mag;
	logic [48:0] crv_sum;
	logic        done_q;
	logic [enpp_pkg::PEN_W-1:0]    penalty_q;
	logic [enpp_pkg::SLP_W-1:0]    slope_q;
	logic [enpp_pkg::CRV_W-1:0]    curvature_q;
	logic [enpp_pkg::REGION_W-1:0] region_q;

	always_comb begin
		fin     = side_d[QW];
		pen_sum = 40'(fin.pen_base) + (fin.in_band ? 40'(quo_p[QW-1:17]) : 40'd0);
		slp_mag = 40'(fin.slope_base) + (fin.in_band ? 40'(quo_s[24:0]) : 40'd0);
		crv_sum = 49'(quo_c) + 49'({l2_q, 8'd0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_d[QW];
		end
	end

	always_ff @(posedge clk) begin
		penalty_q   <= 47'(pen_sum);
		slope_q     <= fin.neg ? (40'd0 - slp_mag) : slp_mag;
		curvature_q <= (crv_sum[48:47] != 2'b00) ? {enpp_pkg::CRV_W{1'b1}} : crv_sum[46:0];
		region_q    <= fin.region;
	end

	assign done      = done_q;
	assign penalty   = penalty_q;
	assign slope     = slope_q;
	assign curvature = curvature_q;
	assign region    = region_q;

`ifndef ASSERT_OFF
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result strobe missing after fixed latency");
	a_region_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (region == enpp_pkg::REGION_IN || region == enpp_pkg::REGION_ABOVE ||
			region == enpp_pkg::REGION_BELOW))
		else $error("region code out of range");
	a_above_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(done && region == enpp_pkg::REGION_ABOVE) |-> !slope[enpp_pkg::SLP_W-1])
		else $error("negative slope above band");
	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_d[QW]))
		else $error("strobe without travelling transaction");
`endif
endmodule
`default_nettype wire
